FILE: src/gdd_pkg.sv
// Shared types, constants and calendar tables for the Gregorian date difference core.
`default_nettype none

package gdd_pkg;

  // Field widths
  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned CountW = 22;
  localparam int unsigned StatW  = 2;
  // Width of a year divided by one hundred
  localparam int unsigned CentW  = 8;
  // Width of the day-of-year offset (up to 366)
  localparam int unsigned DoyW   = 10;
  // Width of the days-before-month table entries
  localparam int unsigned DbmW   = 9;

  // Input and output bus widths
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 24;

  // Calendar constants
  localparam logic [YearW-1:0] YearMax     = 14'd9999;
  localparam logic [MonthW-1:0] MonthFeb   = 4'd2;
  localparam logic [MonthW-1:0] MonthDec   = 4'd12;
  // Reciprocal of 100 scaled by 2^19; exact for every 14-bit dividend
  localparam logic [12:0] Recip100        = 13'd5243;
  localparam int unsigned Recip100Shift   = 19;
  localparam logic [8:0] DaysPerYear      = 9'd365;
  localparam logic [6:0] YearsPerCentury  = 7'd100;

  // Result status codes
  localparam logic [StatW-1:0] StatusOk      = 2'd0;
  localparam logic [StatW-1:0] StatusOrder   = 2'd1;
  localparam logic [StatW-1:0] StatusInvalid = 2'd2;
  localparam logic [StatW-1:0] StatusUnused  = 2'd3;

  // Stage advance enables shared by the date pipelines
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } gdd_adv_t;

  // Length of a month; zero for a month code that is out of range
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] len;
    len = '0;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = '0;
    endcase
    return len;
  endfunction

  // Days of a common year before the first of a month
  function automatic logic [DbmW-1:0] days_before(input logic [MonthW-1:0] m);
    logic [DbmW-1:0] n;
    n = '0;
    case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = '0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: src/gdd_date_pipe.sv
// Three-stage pipeline that checks one date and turns it into a day number.
`default_nettype none

module gdd_date_pipe (
  input  wire                         clk_i,
  input  wire gdd_pkg::gdd_adv_t      adv_i,
  input  wire [gdd_pkg::YearW-1:0]    year_i,
  input  wire [gdd_pkg::MonthW-1:0]   month_i,
  input  wire [gdd_pkg::DayW-1:0]     day_i,
  output logic [gdd_pkg::CountW-1:0]  day_num_o,
  output logic                        date_ok_o
);

  // Stage 1 registers
  logic [gdd_pkg::YearW-1:0]  y1_q, p1_q;
  logic [gdd_pkg::MonthW-1:0] m1_q;
  logic [gdd_pkg::DayW-1:0]   d1_q;
  logic [gdd_pkg::CentW-1:0]  qp1_q, qy1_q;
  logic                       yok1_q;

  // Stage 2 registers
  logic [gdd_pkg::CountW-1:0] ny2_q;
  logic [gdd_pkg::DoyW-1:0]   doy2_q;
  logic                       ok2_q;

  // Stage 3 registers
  logic [gdd_pkg::CountW-1:0] dn3_q;
  logic                       ok3_q;

  // Stage 1 logic: years elapsed and divisions by one hundred
  logic [gdd_pkg::YearW-1:0] p1_d;
  logic [26:0]               prodp, prody;

  assign p1_d  = year_i - gdd_pkg::YearW'(1);
  assign prodp = 27'(p1_d) * 27'(gdd_pkg::Recip100);
  assign prody = 27'(year_i) * 27'(gdd_pkg::Recip100);

  // Capture stage 1
  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      y1_q   <= year_i;
      p1_q   <= p1_d;
      m1_q   <= month_i;
      d1_q   <= day_i;
      qp1_q  <= prodp[gdd_pkg::Recip100Shift +: gdd_pkg::CentW];
      qy1_q  <= prody[gdd_pkg::Recip100Shift +: gdd_pkg::CentW];
      yok1_q <= (year_i != '0) && (year_i <= gdd_pkg::YearMax);
    end
  end

  // Stage 2 logic: leap rule, range check, year and month offsets
  logic [14:0]                cent_y;
  logic                       div100, leap, mok, dok;
  logic [23:0]                ny_full;
  logic [gdd_pkg::DayW-1:0]   mlen;
  logic [gdd_pkg::DoyW-1:0]   doy2_d;

  assign cent_y  = 15'(qy1_q) * 15'(gdd_pkg::YearsPerCentury);
  assign div100  = (15'(y1_q) == cent_y);
  assign leap    = ((y1_q[1:0] == 2'b00) && !div100) || (div100 && (qy1_q[1:0] == 2'b00));
  assign mok     = (m1_q != '0) && (m1_q <= gdd_pkg::MonthDec);
  assign mlen    = gdd_pkg::month_len(m1_q, leap);
  assign dok     = (d1_q != '0) && (d1_q <= mlen);
  assign ny_full = 24'(p1_q) * 24'(gdd_pkg::DaysPerYear) + 24'(p1_q >> 2)
                 - 24'(qp1_q) + 24'(qp1_q >> 2);
  assign doy2_d  = 10'(gdd_pkg::days_before(m1_q)) + 10'(d1_q)
                 + 10'((m1_q > gdd_pkg::MonthFeb) && leap);

  // Capture stage 2
  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      ny2_q  <= ny_full[gdd_pkg::CountW-1:0];
      doy2_q <= doy2_d;
      ok2_q  <= yok1_q && mok && dok;
    end
  end

  // Capture stage 3: final day number
  always_ff @(posedge clk_i) begin
    if (adv_i.s3) begin
      dn3_q <= ny2_q + gdd_pkg::CountW'(doy2_q);
      ok3_q <= ok2_q;
    end
  end

  assign day_num_o = dn3_q;
  assign date_ok_o = ok3_q;

endmodule

`default_nettype wire

FILE: src/gregorian_date_difference_core.sv
// Top level: days between two Gregorian dates, four-stage stream pipeline.
// Path: an accepted request moves through stages 1 to 4 before its result is valid on the master side.
// Throughput: one request per cycle; each stage holds under backpressure and
// refills as soon as its successor moves.
// Reset: rst_ni clears all stage valid bits; payload registers are not reset.
`default_nettype none

module gregorian_date_difference_core (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [13:0] start_year, [17:14] start_month, [22:18] start_day, [36:23] end_year,
  // [40:37] end_month, [45:41] end_day, [46] include_end, [47] zero
  input  wire [gdd_pkg::InDataW-1:0]    s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  wire                           m_axis_tready_i,
  // [21:0] day_count, [23:22] zero
  output logic [gdd_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // [1:0] status
  output logic [gdd_pkg::StatW-1:0]     m_axis_tuser_o
);

  // Stage valid bits and include-end flags
  logic v1_q, v2_q, v3_q, v4_q;
  logic inc1_q, inc2_q, inc3_q;
  logic [gdd_pkg::CountW-1:0] cnt4_q;
  logic [gdd_pkg::StatW-1:0]  stat4_q;

  // Advance chain: a stage moves when it is empty or its successor moves
  logic en1, en2, en3, en4;
  gdd_pkg::gdd_adv_t adv;

  assign en4 = !v4_q || m_axis_tready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign adv = '{s1: en1, s2: en2, s3: en3};

  assign s_axis_tready_o = en1;

  // Convert start and end dates
  logic [gdd_pkg::CountW-1:0] dn_start, dn_end;
  logic                       ok_start, ok_end;

  gdd_date_pipe u_start (
    .clk_i     (clk_i),
    .adv_i     (adv),
    .year_i    (s_axis_tdata_i[13:0]),
    .month_i   (s_axis_tdata_i[17:14]),
    .day_i     (s_axis_tdata_i[22:18]),
    .day_num_o (dn_start),
    .date_ok_o (ok_start)
  );

  gdd_date_pipe u_end (
    .clk_i     (clk_i),
    .adv_i     (adv),
    .year_i    (s_axis_tdata_i[36:23]),
    .month_i   (s_axis_tdata_i[40:37]),
    .day_i     (s_axis_tdata_i[45:41]),
    .day_num_o (dn_end),
    .date_ok_o (ok_end)
  );

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // Carry the include-end flag alongside the date pipes
  always_ff @(posedge clk_i) begin
    if (en1) inc1_q <= s_axis_tdata_i[46];
    if (en2) inc2_q <= inc1_q;
    if (en3) inc3_q <= inc2_q;
  end

  // Compare, subtract and classify
  logic [gdd_pkg::CountW-1:0] cnt4_d;
  logic [gdd_pkg::StatW-1:0]  stat4_d;

  always_comb begin
    cnt4_d  = '0;
    stat4_d = gdd_pkg::StatusOk;
    if (!ok_start || !ok_end) begin
      stat4_d = gdd_pkg::StatusInvalid;
    end else if (dn_start >= dn_end) begin
      stat4_d = gdd_pkg::StatusOrder;
    end else begin
      cnt4_d = dn_end - dn_start + gdd_pkg::CountW'(inc3_q);
    end
  end

  // Hold the result until the master side takes it
  always_ff @(posedge clk_i) begin
    if (en4) begin
      cnt4_q  <= cnt4_d;
      stat4_q <= stat4_d;
    end
  end

  assign m_axis_tvalid_o = v4_q;
  assign m_axis_tdata_o  = {{(gdd_pkg::OutDataW - gdd_pkg::CountW){1'b0}}, cnt4_q};
  assign m_axis_tuser_o  = stat4_q;

  // Checks
  a_no_unused_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o != gdd_pkg::StatusUnused))
    else $error("reserved status code on result");

  a_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o != gdd_pkg::StatusOk)) |-> (cnt4_q == '0))
    else $error("nonzero count with error status");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> v1_q)
    else $error("accepted request lost at stage 1");

  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && v3_q && v4_q && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("request accepted into a full stalled pipeline");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && v4_q && !m_axis_tready_i) |=> v3_q)
    else $error("stage 3 dropped while stalled");

endmodule

`default_nettype wire
